// ===== design/r2hsv_pkg.sv =====
// shared widths and constants for the rgb to hsv pixel converter
package r2hsv_pkg;

    localparam int CH_W    = 8;
    localparam int HUE_W   = 9;
    localparam int MILLI_W = 10;

    // restoring divider: numerator, quotient and number of pipelined steps
    localparam int NUM_W     = 18;
    localparam int QUO_W     = 10;
    localparam int DIV_STEPS = QUO_W;
    localparam int REM_W     = CH_W;

    localparam logic [HUE_W-1:0]   HUE_OFS_RED   = 9'd0;
    localparam logic [HUE_W-1:0]   HUE_OFS_WRAP  = 9'd360;
    localparam logic [HUE_W-1:0]   HUE_OFS_GREEN = 9'd120;
    localparam logic [HUE_W-1:0]   HUE_OFS_BLUE  = 9'd240;
    localparam logic [NUM_W-1:0]   HUE_SCALE     = 18'd60;
    localparam logic [NUM_W-1:0]   MILLI_SCALE   = 18'd1000;
    localparam logic [MILLI_W-1:0] MILLI_FULL    = 10'd1000;

    // x / 255 approximated by x * 257 / 65536, then one correction step
    localparam int               RECIP_W     = 9;
    localparam int               RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_255 = 9'd257;
    localparam logic [NUM_W-1:0] CH_FULL     = 18'd255;
    localparam int               PROD_W      = NUM_W + RECIP_W;

endpackage

// ===== design/rgb_to_hsv_pixel_top.sv =====
// rgb to hsv pixel converter, fully pipelined, one pixel per clock while hsv_ready does not stall
//
//   channel   handshake                  payload
//   pixel in  pixel_valid / pixel_ready  red, green, blue, last_pixel_in
//   hsv out   hsv_valid / hsv_ready      hue, sat_milli, val_milli, last_pixel_out
//
// one pixel is accepted every cycle while the output moves; the pipeline is
// the min/max stage, the divider load stage, ten restoring divider steps and the
// output register
// the two divisions (hue and saturation) run side by side, one quotient bit per stage
// reset clears only the stage valid bits
// a stall on hsv_ready freezes the whole pipeline; pixel_ready follows it
module rgb_to_hsv_pixel_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic [r2hsv_pkg::CH_W-1:0]     red,
    input  logic [r2hsv_pkg::CH_W-1:0]     green,
    input  logic [r2hsv_pkg::CH_W-1:0]     blue,
    input  logic                           last_pixel_in,
    output logic                           hsv_valid,
    input  logic                           hsv_ready,
    output logic [r2hsv_pkg::HUE_W-1:0]    hue,
    output logic [r2hsv_pkg::MILLI_W-1:0]  sat_milli,
    output logic [r2hsv_pkg::MILLI_W-1:0]  val_milli,
    output logic                           last_pixel_out
);
    import r2hsv_pkg::*;

    logic adv;

    // stage a: max, min and hue difference
    logic             a_valid_reg;
    logic [CH_W-1:0]  a_mx_reg, a_mn_reg, a_den_reg, a_mag_reg;
    logic             a_neg_reg, a_grey_reg, a_last_reg;
    logic [HUE_W-1:0] a_ofs_reg;

    logic [CH_W-1:0]  a_mx_next, a_mn_next, a_mag_next;
    logic             a_neg_next;
    logic [HUE_W-1:0] a_ofs_next;

    // divider stages, index is the number of steps done
    logic               st_valid_reg [0:DIV_STEPS];
    logic [REM_W-1:0]   h_rem_reg    [0:DIV_STEPS];
    logic [QUO_W-1:0]   h_low_reg    [0:DIV_STEPS];
    logic [QUO_W-1:0]   h_quo_reg    [0:DIV_STEPS];
    logic [REM_W-1:0]   s_rem_reg    [0:DIV_STEPS];
    logic [QUO_W-1:0]   s_low_reg    [0:DIV_STEPS];
    logic [QUO_W-1:0]   s_quo_reg    [0:DIV_STEPS];
    logic [CH_W-1:0]    h_den_reg    [0:DIV_STEPS];
    logic [CH_W-1:0]    s_den_reg    [0:DIV_STEPS];
    logic               grey_reg     [0:DIV_STEPS];
    logic               neg_reg      [0:DIV_STEPS];
    logic               szero_reg    [0:DIV_STEPS];
    logic               last_reg     [0:DIV_STEPS];
    logic [HUE_W-1:0]   ofs_reg      [0:DIV_STEPS];
    logic [MILLI_W-1:0] val_reg      [2:DIV_STEPS];

    logic [REM_W-1:0]   h_rem_next   [1:DIV_STEPS];
    logic [QUO_W-1:0]   h_quo_next   [1:DIV_STEPS];
    logic [REM_W-1:0]   s_rem_next   [1:DIV_STEPS];
    logic [QUO_W-1:0]   s_quo_next   [1:DIV_STEPS];

    // value lane: x = max * 1000, first guess, then corrected
    logic [NUM_W-1:0]   vx0_reg, vx1_reg;
    logic [MILLI_W-1:0] vq1_reg;
    logic [PROD_W-1:0]  vprod;
    logic [NUM_W-1:0]   vres;
    logic [MILLI_W-1:0] val_next;

    logic [NUM_W-1:0]   hnum, snum;

    // output register
    logic               out_valid_reg;
    logic [HUE_W-1:0]   hue_reg, hue_next;
    logic [MILLI_W-1:0] sat_reg, sat_next;
    logic [MILLI_W-1:0] val_out_reg;
    logic               last_out_reg;

    assign adv         = !out_valid_reg || hsv_ready;
    assign pixel_ready = adv;

    // largest channel, red wins ties, then green
    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            a_mx_next = red;
            if (green >= blue)
            begin
                a_mag_next = green - blue;
                a_neg_next = 1'b0;
                a_ofs_next = HUE_OFS_RED;
            end
            else
            begin
                a_mag_next = blue - green;
                a_neg_next = 1'b1;
                a_ofs_next = HUE_OFS_WRAP;
            end
        end
        else if (green >= blue)
        begin
            a_mx_next  = green;
            a_ofs_next = HUE_OFS_GREEN;
            a_neg_next = (blue < red);
            a_mag_next = (blue < red) ? (red - blue) : (blue - red);
        end
        else
        begin
            a_mx_next  = blue;
            a_ofs_next = HUE_OFS_BLUE;
            a_neg_next = (red < green);
            a_mag_next = (red < green) ? (green - red) : (red - green);
        end

        if (red <= green && red <= blue)
            a_mn_next = red;
        else if (green <= blue)
            a_mn_next = green;
        else
            a_mn_next = blue;
    end

    // divider numerators
    always_comb
    begin
        hnum = NUM_W'(a_mag_reg) * HUE_SCALE;
        snum = NUM_W'(a_mn_reg) * MILLI_SCALE;
    end

    // one restoring step per stage for both lanes
    always_comb
    begin
        logic [REM_W:0] t_h, t_s;
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            t_h = {h_rem_reg[j-1], h_low_reg[j-1][QUO_W-1]};
            t_s = {s_rem_reg[j-1], s_low_reg[j-1][QUO_W-1]};
            if (t_h >= {1'b0, h_den_reg[j-1]})
            begin
                h_rem_next[j] = REM_W'(t_h - {1'b0, h_den_reg[j-1]});
                h_quo_next[j] = {h_quo_reg[j-1][QUO_W-2:0], 1'b1};
            end
            else
            begin
                h_rem_next[j] = t_h[REM_W-1:0];
                h_quo_next[j] = {h_quo_reg[j-1][QUO_W-2:0], 1'b0};
            end
            if (t_s >= {1'b0, s_den_reg[j-1]})
            begin
                s_rem_next[j] = REM_W'(t_s - {1'b0, s_den_reg[j-1]});
                s_quo_next[j] = {s_quo_reg[j-1][QUO_W-2:0], 1'b1};
            end
            else
            begin
                s_rem_next[j] = t_s[REM_W-1:0];
                s_quo_next[j] = {s_quo_reg[j-1][QUO_W-2:0], 1'b0};
            end
        end
    end

    // value: guess is at most one low, fix with one compare
    always_comb
    begin
        vprod    = PROD_W'(vx0_reg) * PROD_W'(RECIP_255);
        vres     = vx1_reg - NUM_W'(vq1_reg) * CH_FULL;
        val_next = (vres >= CH_FULL) ? (vq1_reg + 1'b1) : vq1_reg;
    end

    // final hue and saturation
    always_comb
    begin
        if (grey_reg[DIV_STEPS])
            hue_next = '0;
        else if (neg_reg[DIV_STEPS])
            hue_next = ofs_reg[DIV_STEPS] - h_quo_reg[DIV_STEPS][HUE_W-1:0];
        else
            hue_next = ofs_reg[DIV_STEPS] + h_quo_reg[DIV_STEPS][HUE_W-1:0];

        if (szero_reg[DIV_STEPS])
            sat_next = '0;
        else
            sat_next = MILLI_FULL - s_quo_reg[DIV_STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++)
                st_valid_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg     <= pixel_valid;
            st_valid_reg[0] <= a_valid_reg;
            for (int j = 1; j <= DIV_STEPS; j++)
                st_valid_reg[j] <= st_valid_reg[j-1];
            out_valid_reg   <= st_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mx_reg   <= a_mx_next;
            a_mn_reg   <= a_mn_next;
            a_den_reg  <= a_mx_next - a_mn_next;
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_ofs_reg  <= a_ofs_next;
            a_grey_reg <= (a_mx_next == a_mn_next);
            a_last_reg <= last_pixel_in;

            h_rem_reg[0] <= hnum[NUM_W-1:QUO_W];
            h_low_reg[0] <= hnum[QUO_W-1:0];
            h_quo_reg[0] <= '0;
            s_rem_reg[0] <= snum[NUM_W-1:QUO_W];
            s_low_reg[0] <= snum[QUO_W-1:0];
            s_quo_reg[0] <= '0;
            h_den_reg[0] <= a_den_reg;
            s_den_reg[0] <= a_mx_reg;
            grey_reg[0]  <= a_grey_reg;
            neg_reg[0]   <= a_neg_reg;
            szero_reg[0] <= (a_mx_reg == '0);
            last_reg[0]  <= a_last_reg;
            ofs_reg[0]   <= a_ofs_reg;
            vx0_reg      <= NUM_W'(a_mx_reg) * MILLI_SCALE;

            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                h_rem_reg[j] <= h_rem_next[j];
                h_low_reg[j] <= {h_low_reg[j-1][QUO_W-2:0], 1'b0};
                h_quo_reg[j] <= h_quo_next[j];
                s_rem_reg[j] <= s_rem_next[j];
                s_low_reg[j] <= {s_low_reg[j-1][QUO_W-2:0], 1'b0};
                s_quo_reg[j] <= s_quo_next[j];
                h_den_reg[j] <= h_den_reg[j-1];
                s_den_reg[j] <= s_den_reg[j-1];
                grey_reg[j]  <= grey_reg[j-1];
                neg_reg[j]   <= neg_reg[j-1];
                szero_reg[j] <= szero_reg[j-1];
                last_reg[j]  <= last_reg[j-1];
                ofs_reg[j]   <= ofs_reg[j-1];
            end

            vx1_reg    <= vx0_reg;
            vq1_reg    <= vprod[RECIP_SHIFT+MILLI_W-1:RECIP_SHIFT];
            val_reg[2] <= val_next;
            for (int j = 3; j <= DIV_STEPS; j++)
                val_reg[j] <= val_reg[j-1];

            hue_reg      <= hue_next;
            sat_reg      <= sat_next;
            val_out_reg  <= val_reg[DIV_STEPS];
            last_out_reg <= last_reg[DIV_STEPS];
        end
    end

    assign hsv_valid      = out_valid_reg;
    assign hue            = hue_reg;
    assign sat_milli      = sat_reg;
    assign val_milli      = val_out_reg;
    assign last_pixel_out = last_out_reg;

endmodule

// ===== bench/tb_rgb_to_hsv_pixel_top.sv =====
// self-checking bench for the rgb to hsv pixel converter
module tb_rgb_to_hsv_pixel_top;
    timeunit 1ns;
    timeprecision 1ps;

    import r2hsv_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 26;
    localparam int MAX_PRINTS     = 60;
    localparam int N_PHASES       = 5;
    localparam int PHASE_ITEMS    = 256;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [MILLI_W-1:0] sat;
        logic [MILLI_W-1:0] val;
        logic               last;
    } hsv_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_ready;
    logic [CH_W-1:0]      red = '0;
    logic [CH_W-1:0]      green = '0;
    logic [CH_W-1:0]      blue = '0;
    logic                 last_pixel_in = 1'b0;
    logic                 hsv_valid;
    logic                 hsv_ready = 1'b0;
    logic [HUE_W-1:0]     hue;
    logic [MILLI_W-1:0]   sat_milli;
    logic [MILLI_W-1:0]   val_milli;
    logic                 last_pixel_out;

    pixel_t pixel_queue[$];
    hsv_t   hsv_expected[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int hold_count = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    rgb_to_hsv_pixel_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .last_pixel_in  (last_pixel_in),
        .hsv_valid      (hsv_valid),
        .hsv_ready      (hsv_ready),
        .hue            (hue),
        .sat_milli      (sat_milli),
        .val_milli      (val_milli),
        .last_pixel_out (last_pixel_out)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic hsv_t rgb_to_hsv_calc(pixel_t px);
        hsv_t res;
        int r;
        int g;
        int b;
        int mx;
        int mn;
        int diff;
        int q;
        int ofs;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        diff = 0;
        ofs = 0;
        // red wins ties for the largest channel, then green
        if (mx == r)
        begin
            diff = g - b;
            ofs = (g >= b) ? 0 : 360;
        end
        else if (mx == g)
        begin
            diff = b - r;
            ofs = 120;
        end
        else
        begin
            diff = r - g;
            ofs = 240;
        end
        if (mx == mn)
        begin
            res.hue = '0;
        end
        else
        begin
            // truncate toward zero on the magnitude, then apply the sign
            q = (diff >= 0) ? (60 * diff) / (mx - mn) : (60 * (-diff)) / (mx - mn);
            res.hue = HUE_W'((diff >= 0) ? ofs + q : ofs - q);
        end
        res.sat = (mx == 0) ? '0 : MILLI_W'(1000 - (mn * 1000) / mx);
        res.val = MILLI_W'((mx * 1000) / 255);
        res.last = px.last;
        return res;
    endfunction

    function automatic logic [CH_W-1:0] pick_extreme();
        int k;
        k = $urandom_range(3);
        case (k)
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        int mode;
        int base;
        mode = $urandom_range(9);
        px.red = 8'($urandom);
        px.green = 8'($urandom);
        px.blue = 8'($urandom);
        px.last = ($urandom_range(7) == 0);
        case (mode)
            5:
            begin
                // almost grey: tiny spread gives large hue steps
                base = $urandom_range(255);
                px.red = 8'(base);
                px.green = 8'((base + $urandom_range(2)) > 255 ? 255 : base + $urandom_range(2));
                px.blue = 8'((base >= 2) ? base - $urandom_range(2) : base);
            end
            6:
            begin
                // two channels tied
                case ($urandom_range(2))
                    0: px.green = px.red;
                    1: px.blue = px.green;
                    default: px.blue = px.red;
                endcase
            end
            7:
            begin
                px.red = pick_extreme();
                px.green = pick_extreme();
                px.blue = pick_extreme();
            end
            8:
            begin
                px.red = 8'($urandom_range(3));
                px.green = 8'($urandom_range(3));
                px.blue = 8'($urandom_range(3));
            end
            9:
            begin
                // one channel saturated, others random
                case ($urandom_range(2))
                    0: px.red = 8'd255;
                    1: px.green = 8'd255;
                    default: px.blue = 8'd255;
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic push_pixel(input int r, input int g, input int b, input bit l);
        pixel_t px;
        px.red = 8'(r);
        px.green = 8'(g);
        px.blue = 8'(b);
        px.last = l;
        pixel_queue.push_back(px);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTS)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver: next word loads when the slot is empty or the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            red <= '0;
            green <= '0;
            blue <= '0;
            last_pixel_in <= 1'b0;
        end
        else if (!pixel_valid || pixel_ready)
        begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pixel_t px;
                px = pixel_queue.pop_front();
                pixel_valid <= 1'b1;
                red <= px.red;
                green <= px.green;
                blue <= px.blue;
                last_pixel_in <= px.last;
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_ready <= 1'b0;
            hold_count <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hsv_ready <= 1'b0;
            if (hold_count >= HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            hsv_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!hold_req)
            begin
                hold_done <= 1'b0;
                hold_count <= 0;
            end
        end
    end

    // monitor: predict on input words, check output words in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
                hsv_expected.push_back(rgb_to_hsv_calc({red, green, blue, last_pixel_in}));
            if (hsv_valid && hsv_ready)
            begin
                if (hsv_expected.size() == 0)
                begin
                    report_mismatch("unexpected word, hue", hue, 0);
                end
                else
                begin
                    hsv_t want;
                    want = hsv_expected.pop_front();
                    if (hue !== want.hue)
                        report_mismatch("hue", hue, want.hue);
                    if (sat_milli !== want.sat)
                        report_mismatch("sat_milli", sat_milli, want.sat);
                    if (val_milli !== want.val)
                        report_mismatch("val_milli", val_milli, want.val);
                    if (last_pixel_out !== want.last)
                        report_mismatch("last_pixel_out", last_pixel_out, want.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        int i;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: grey, black, white, primaries, ties, hue wrap
        push_pixel(0, 0, 0, 0);
        push_pixel(255, 255, 255, 1);
        push_pixel(128, 128, 128, 0);
        push_pixel(255, 0, 0, 0);
        push_pixel(0, 255, 0, 0);
        push_pixel(0, 0, 255, 1);
        push_pixel(255, 255, 0, 0);
        push_pixel(0, 255, 255, 0);
        push_pixel(255, 0, 255, 0);
        push_pixel(255, 128, 0, 0);
        push_pixel(255, 0, 128, 0);
        push_pixel(255, 0, 1, 1);
        push_pixel(100, 255, 50, 0);
        push_pixel(50, 255, 100, 0);
        push_pixel(60, 30, 255, 0);
        push_pixel(30, 60, 255, 0);
        push_pixel(1, 0, 0, 0);
        push_pixel(0, 0, 1, 0);
        push_pixel(0, 1, 1, 1);
        push_pixel(254, 1, 0, 0);
        push_pixel(255, 254, 255, 0);
        push_pixel(1, 1, 0, 0);
        push_pixel(255, 255, 254, 1);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            @(negedge clk);
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 71;
                end
                3:
                begin
                    send_idle_pct = 37;
                    recv_stall_pct = 37;
                end
                default:
                begin
                    // long hold-off while words keep coming: pipeline fills up
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_req = 1'b1;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
                pixel_queue.push_back(rand_pixel());
            if (hold_req)
            begin
                while (!hold_done) @(negedge clk);
                hold_req = 1'b0;
            end
            while (pixel_queue.size() > 0 || pixel_valid) @(negedge clk);
            // after phases 1 and 3 the sender pauses until every expected word has come back
            if (ph == 1 || ph == 3)
                while (hsv_expected.size() > 0) @(negedge clk);
        end

        while (hsv_expected.size() > 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (error_count == 0 && hsv_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
